// ----- rtl/stkt_pkg.sv -----
// ----------------------------------------------------------------------------
// stkt_pkg
// Shared widths, register codes and pipeline payload types of the Student-t
// kernel table point generator.
// ----------------------------------------------------------------------------
package stkt_pkg;

   localparam int COORD_W   = 7;
   localparam int SUPPORT_W = 16;
   localparam int RADIUS_W  = 6;
   localparam int IDX_W     = 13;
   localparam int WEIGHT_W  = 17;
   localparam int GRAD_W    = 16;
   localparam int MAG_W     = 15;
   localparam int OFS_Q_W   = 16;   // quotient bits of the offset divide
   localparam int SQ_W      = 2 * MAG_W;
   localparam int DEN_W     = 32;   // 1.0 + x^2 + y^2 in Q16.16
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   localparam int DEF_MAX_RADIUS = 32;

   localparam logic [RADIUS_W-1:0]  RADIUS_RST  = RADIUS_W'(32);
   localparam logic [SUPPORT_W-1:0] SUPPORT_RST = SUPPORT_W'(256);
   localparam logic [MAG_W-1:0]     MAG_MAX     = {MAG_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPORT = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             neg_x;
   } front_sb_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [MAG_W-1:0] xm;
      logic [MAG_W-1:0] ym;
      logic             nx;
      logic             ny;
   } point_type;

endpackage

// ----- rtl/stkt_div.sv -----
// ----------------------------------------------------------------------------
// stkt_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
module stkt_div #(
   parameter int DEN_W = 8,
   parameter int Q_W   = 8,
   parameter int SB_W  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [Q_W+DEN_W-1:0] in_num,
   input  logic [DEN_W-1:0]     in_den,
   input  logic [SB_W-1:0]      in_sb,
   output logic                 out_valid,
   output logic [Q_W-1:0]       out_quo,
   output logic [SB_W-1:0]      out_sb
);

   logic             v_ff   [0:Q_W];
   logic [DEN_W-1:0] rem_ff [0:Q_W];
   logic [Q_W-1:0]   lo_ff  [0:Q_W];
   logic [Q_W-1:0]   quo_ff [0:Q_W];
   logic [DEN_W-1:0] den_ff [0:Q_W];
   logic [SB_W-1:0]  sb_ff  [0:Q_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      rem_ff[0] <= in_num[Q_W+DEN_W-1:Q_W];
      lo_ff[0]  <= in_num[Q_W-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= in_den;
      sb_ff[0]  <= in_sb;
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;
      logic [DEN_W:0] diff;
      logic [DEN_W-1:0] rem_in;

      assign trial  = {rem_ff[k-1], lo_ff[k-1][Q_W-1]};
      assign ge     = trial >= {1'b0, den_ff[k-1]};
      assign diff   = trial - {1'b0, den_ff[k-1]};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_ff[k-1];
         end
         rem_ff[k] <= rem_in;
         lo_ff[k]  <= {lo_ff[k-1][Q_W-2:0], 1'b0};
         quo_ff[k] <= {quo_ff[k-1][Q_W-2:0], ge};
         den_ff[k] <= den_ff[k-1];
         sb_ff[k]  <= sb_ff[k-1];
      end
   end

   assign out_valid = v_ff[Q_W];
   assign out_quo   = quo_ff[Q_W];
   assign out_sb    = sb_ff[Q_W];

endmodule

// ----- rtl/stkt_front.sv -----
// ----------------------------------------------------------------------------
// stkt_front
// Clamp the coordinates, form the table index and the rounded-offset
// dividends |c-R|*support*2+R over 2R.
// ----------------------------------------------------------------------------
module stkt_front
   import stkt_pkg::*;
#(
   parameter int RW = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [COORD_W-1:0]      in_col,
   input  logic [COORD_W-1:0]      in_row,
   input  logic [RW-1:0]           radius,
   input  logic [SUPPORT_W-1:0]    support,
   output logic                    out_valid,
   output logic [OFS_Q_W+RW:0]     out_num_x,
   output logic [OFS_Q_W+RW:0]     out_num_y,
   output logic [RW:0]             out_den,
   output front_sb_type            out_sb,
   output logic                    out_neg_y
);

   logic [RW:0]          top;
   logic [COORD_W-1:0]   col_c;
   logic [COORD_W-1:0]   row_c;
   logic [RW-1:0]        ad_x;
   logic [RW-1:0]        ad_y;
   logic [OFS_Q_W+RW:0]  num_x_in;
   logic [OFS_Q_W+RW:0]  num_y_in;
   logic [IDX_W-1:0]     idx_in;
   logic                 valid_ff;
   logic [OFS_Q_W+RW:0]  num_x_ff;
   logic [OFS_Q_W+RW:0]  num_y_ff;
   logic [RW:0]          den_ff;
   front_sb_type         sb_ff;
   logic                 neg_y_ff;

   always_comb begin
      top   = {radius, 1'b0};
      col_c = (32'(in_col) > 32'(top)) ? COORD_W'(top) : in_col;
      row_c = (32'(in_row) > 32'(top)) ? COORD_W'(top) : in_row;
      ad_x  = (32'(col_c) >= 32'(radius)) ? RW'(32'(col_c) - 32'(radius))
                                          : RW'(32'(radius) - 32'(col_c));
      ad_y  = (32'(row_c) >= 32'(radius)) ? RW'(32'(row_c) - 32'(radius))
                                          : RW'(32'(radius) - 32'(row_c));
      num_x_in = {(OFS_Q_W+RW)'(ad_x) * (OFS_Q_W+RW)'(support), 1'b0}
                 + (OFS_Q_W+RW+1)'(radius);
      num_y_in = {(OFS_Q_W+RW)'(ad_y) * (OFS_Q_W+RW)'(support), 1'b0}
                 + (OFS_Q_W+RW+1)'(radius);
      idx_in   = IDX_W'(32'(row_c) * (32'(top) + 32'd1) + 32'(col_c));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      num_x_ff     <= num_x_in;
      num_y_ff     <= num_y_in;
      den_ff       <= top;
      sb_ff.idx    <= idx_in;
      sb_ff.neg_x  <= 32'(col_c) < 32'(radius);
      neg_y_ff     <= 32'(row_c) < 32'(radius);
   end

   assign out_valid = valid_ff;
   assign out_num_x = num_x_ff;
   assign out_num_y = num_y_ff;
   assign out_den   = den_ff;
   assign out_sb    = sb_ff;
   assign out_neg_y = neg_y_ff;

endmodule

// ----- rtl/stkt_grad.sv -----
// ----------------------------------------------------------------------------
// stkt_grad
// Gradient terms t*t*x and t*t*y: square, scale, round and sign, then
// drive the result registers.
// ----------------------------------------------------------------------------
module stkt_grad
   import stkt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [WEIGHT_W-1:0]  in_t,
   input  point_type            in_pt,
   output logic                 out_valid,
   output logic [IDX_W-1:0]     out_idx,
   output logic [WEIGHT_W-1:0]  out_weight,
   output logic [GRAD_W-1:0]    out_grad_x,
   output logic [GRAD_W-1:0]    out_grad_y
);

   localparam int TT_W = 2 * WEIGHT_W;
   localparam int P_W  = TT_W + MAG_W;

   logic                v1_ff;
   logic [TT_W-1:0]     tt_ff;
   logic [WEIGHT_W-1:0] t1_ff;
   point_type           pt1_ff;

   logic                v2_ff;
   logic [P_W-1:0]      px_ff;
   logic [P_W-1:0]      py_ff;
   logic [WEIGHT_W-1:0] t2_ff;
   point_type           pt2_ff;

   logic [P_W:0]        rx;
   logic [P_W:0]        ry;
   logic [GRAD_W-1:0]   gx;
   logic [GRAD_W-1:0]   gy;
   logic [GRAD_W-1:0]   gx_in;
   logic [GRAD_W-1:0]   gy_in;

   logic                v3_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic [GRAD_W-1:0]   gx_ff;
   logic [GRAD_W-1:0]   gy_ff;

   always_comb begin
      rx    = {1'b0, px_ff} + ((P_W+1)'(1) << 39);
      ry    = {1'b0, py_ff} + ((P_W+1)'(1) << 39);
      gx    = GRAD_W'(rx[P_W:40]);
      gy    = GRAD_W'(ry[P_W:40]);
      gx_in = pt2_ff.nx ? GRAD_W'(-gx) : gx;
      gy_in = pt2_ff.ny ? GRAD_W'(-gy) : gy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      tt_ff  <= in_t * in_t;
      t1_ff  <= in_t;
      pt1_ff <= in_pt;
      px_ff  <= tt_ff * pt1_ff.xm;
      py_ff  <= tt_ff * pt1_ff.ym;
      t2_ff  <= t1_ff;
      pt2_ff <= pt1_ff;
      idx_ff <= pt2_ff.idx;
      w_ff   <= t2_ff;
      gx_ff  <= gx_in;
      gy_ff  <= gy_in;
   end

   assign out_valid  = v3_ff;
   assign out_idx    = idx_ff;
   assign out_weight = w_ff;
   assign out_grad_x = gx_ff;
   assign out_grad_y = gy_ff;

endmodule

// ----- rtl/student_t_kernel_table_point.sv -----
// ----------------------------------------------------------------------------
// student_t_kernel_table_point
// Student-t kernel table point: index, weight 1/(1+x^2+y^2) and gradient
// terms t^2*x, t^2*y for one grid coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: pulse start with req_col/req_row. busy is always low, so
//   a request is taken on every cycle start is high, one per clock.
//   Response channel: rsp_valid strobes for one cycle with the index, weight
//   and gradients. The receiver cannot stall; responses leave in request
//   order, one per cycle at most.
//   A request passes the front stage, the offset dividers (one quotient bit
//   per stage), the 2 magnitude and square stages, the weight divider and
//   the 3 gradient stages. The two dividers set the depth; throughput is
//   one request per cycle.
//   CSR port: csr_we writes csr_wdata to register csr_index (0 radius,
//   1 support) at once. Write only while no request is in flight.
//   Reset clears the pipeline valid bits and restores radius 32 and
//   support 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module student_t_kernel_table_point
   import stkt_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_W-1:0]    req_col,
   input  logic [COORD_W-1:0]    req_row,
   output logic                  rsp_valid,
   output logic [IDX_W-1:0]      rsp_entry_index,
   output logic [WEIGHT_W-1:0]   rsp_weight,
   output logic [GRAD_W-1:0]     rsp_grad_x,
   output logic [GRAD_W-1:0]     rsp_grad_y,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int ONUM_W = OFS_Q_W + RW + 1;

   // Configuration registers
   logic [RADIUS_W-1:0]  radius_ff;
   logic [SUPPORT_W-1:0] support_ff;
   logic [RW-1:0]        radius_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RST;
         support_ff <= SUPPORT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS:  radius_ff  <= csr_wdata[RADIUS_W-1:0];
            CSR_SUPPORT: support_ff <= csr_wdata[SUPPORT_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero radius acts as one; clip to the largest supported grid.
   always_comb begin
      if (radius_ff == '0) begin
         radius_eff = RW'(1);
      end else if (32'(radius_ff) > MAX_RADIUS) begin
         radius_eff = RW'(MAX_RADIUS);
      end else begin
         radius_eff = RW'(radius_ff);
      end
   end

   assign busy = 1'b0;

   // Front: clamp, index, offset dividends
   logic              f_valid;
   logic [ONUM_W-1:0] f_num_x;
   logic [ONUM_W-1:0] f_num_y;
   logic [RW:0]       f_den;
   front_sb_type      f_sb;
   logic              f_neg_y;

   stkt_front #(.RW(RW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_col    (req_col),
      .in_row    (req_row),
      .radius    (radius_eff),
      .support   (support_ff),
      .out_valid (f_valid),
      .out_num_x (f_num_x),
      .out_num_y (f_num_y),
      .out_den   (f_den),
      .out_sb    (f_sb),
      .out_neg_y (f_neg_y)
   );

   // Rounded offsets, x and y in lockstep
   logic                             dx_valid;
   logic [OFS_Q_W-1:0]               qx;
   logic [OFS_Q_W-1:0]               qy;
   logic [$bits(front_sb_type)-1:0]  dx_sb;
   logic                             dy_valid;
   logic                             dy_neg;
   front_sb_type                     dx_pt;

   stkt_div #(.DEN_W(RW + 1), .Q_W(OFS_Q_W), .SB_W($bits(front_sb_type))) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_num    (f_num_x),
      .in_den    (f_den),
      .in_sb     (f_sb),
      .out_valid (dx_valid),
      .out_quo   (qx),
      .out_sb    (dx_sb)
   );

   stkt_div #(.DEN_W(RW + 1), .Q_W(OFS_Q_W), .SB_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_num    (f_num_y),
      .in_den    (f_den),
      .in_sb     (f_neg_y),
      .out_valid (dy_valid),
      .out_quo   (qy),
      .out_sb    (dy_neg)
   );

   assign dx_pt = front_sb_type'(dx_sb);

   // Saturate magnitudes; a zero offset carries no sign.
   logic      m_valid_ff;
   point_type m_pt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= dx_valid & dy_valid;
      end
      m_pt_ff.idx <= dx_pt.idx;
      m_pt_ff.xm  <= (qx > OFS_Q_W'(MAG_MAX)) ? MAG_MAX : qx[MAG_W-1:0];
      m_pt_ff.ym  <= (qy > OFS_Q_W'(MAG_MAX)) ? MAG_MAX : qy[MAG_W-1:0];
      m_pt_ff.nx  <= dx_pt.neg_x & (qx != '0);
      m_pt_ff.ny  <= dy_neg & (qy != '0);
   end

   // Squares of the offsets
   logic             s_valid_ff;
   logic [SQ_W-1:0]  sx_ff;
   logic [SQ_W-1:0]  sy_ff;
   point_type        s_pt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= m_valid_ff;
      end
      sx_ff   <= m_pt_ff.xm * m_pt_ff.xm;
      sy_ff   <= m_pt_ff.ym * m_pt_ff.ym;
      s_pt_ff <= m_pt_ff;
   end

   // Weight: round(2^32 / (1.0 + x^2 + y^2)), ties up
   localparam int WNUM_W = WEIGHT_W + DEN_W;

   logic [DEN_W-1:0]  w_den;
   logic [WNUM_W-1:0] w_num;
   logic              w_valid;
   logic [WEIGHT_W-1:0] w_t;
   logic [$bits(point_type)-1:0] w_sb;

   assign w_den = DEN_W'(33'd65536 + 33'(sx_ff) + 33'(sy_ff));
   assign w_num = (WNUM_W'(1) << 32) + WNUM_W'(w_den >> 1);

   stkt_div #(.DEN_W(DEN_W), .Q_W(WEIGHT_W), .SB_W($bits(point_type))) u_div_w (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid_ff),
      .in_num    (w_num),
      .in_den    (w_den),
      .in_sb     (s_pt_ff),
      .out_valid (w_valid),
      .out_quo   (w_t),
      .out_sb    (w_sb)
   );

   // Gradients and response registers
   stkt_grad u_grad (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (w_valid),
      .in_t       (w_t),
      .in_pt      (point_type'(w_sb)),
      .out_valid  (rsp_valid),
      .out_idx    (rsp_entry_index),
      .out_weight (rsp_weight),
      .out_grad_x (rsp_grad_x),
      .out_grad_y (rsp_grad_y)
   );

`ifndef SYNTHESIS
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight <= WEIGHT_W'(65536))
      else $error("weight above 1.0");

   a_flat_at_center: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_weight == WEIGHT_W'(65536) |-> rsp_grad_x == '0 && rsp_grad_y == '0)
      else $error("nonzero gradient at zero offset");

   a_xy_lockstep: assert property (@(posedge clock) disable iff (reset)
      dx_valid == dy_valid)
      else $error("offset dividers out of step");
`endif

endmodule
